// ===== src/vnorm_pkg.sv =====
// Shared types and constants for the four-component vector normalizer.
`default_nettype none

package vnorm_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int UNIT_BITS      = 16;
  localparam int LENGTH_BITS    = 18;
  localparam int QUOT_BITS      = 15;
  localparam int ROOT_BITS      = 32;
  localparam int RAD_BITS       = 2 * ROOT_BITS;
  localparam int NUM_BITS       = 48;
  localparam int DEN_BITS       = ROOT_BITS + 2;
  localparam int LANES          = 4;

  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] comp_x;
    logic signed [COMPONENT_BITS-1:0] comp_y;
    logic signed [COMPONENT_BITS-1:0] comp_z;
    logic signed [COMPONENT_BITS-1:0] comp_w;
  } vec_beat_t;

  typedef struct packed {
    logic signed [UNIT_BITS-1:0]  unit_x;
    logic signed [UNIT_BITS-1:0]  unit_y;
    logic signed [UNIT_BITS-1:0]  unit_z;
    logic signed [UNIT_BITS-1:0]  unit_w;
    logic        [LENGTH_BITS-1:0] length;
    logic                          was_zero;
  } res_beat_t;

endpackage

`default_nettype wire

// ===== src/vec4_normalize_core.sv =====
// Top level of the four-component fixed-point vector normalizer.
//
//   channel | valid     | stall     | beat                 | content
//   input   | vec_valid | vec_stall | vec_data (vec_beat) | x, y, z, w in Q4.12
//   result  | res_valid | res_stall | res_data (res_beat) | unit vector Q1.14, length Q5.12
//
// One vector enters per cycle while vec_stall is low; each result passes through four front
// stages, five normalization stages, 16 square-root stages, one prep stage, 15 divider stages
// and the output register.
// Reset clears only the stage valid bits and the output and skid flags.
// A stalled result beat is held in the output register; one more beat lands in the skid
// register, and vec_stall rises only while the skid register is full.
`default_nettype none

module vec4_normalize_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  vec_valid,
  output logic                       vec_stall,
  input  wire vnorm_pkg::vec_beat_t  vec_data,
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output vnorm_pkg::res_beat_t       res_data
);

  localparam int N       = vnorm_pkg::COMPONENT_BITS;
  localparam int L       = vnorm_pkg::LANES;
  localparam int SUM_W   = 2 * N + 1;
  localparam int RB      = vnorm_pkg::ROOT_BITS;
  localparam int RAD_W   = vnorm_pkg::RAD_BITS;
  localparam int LEN_OFS = N - 16;
  localparam int NORM_ST = 5;

  typedef struct packed {
    logic [L-1:0][N-1:0] mag;
    logic [L-1:0]        neg;
    logic                zero;
    logic                full;
    logic [4:0]          k;
  } sq_side_t;

  typedef struct packed {
    logic [L-1:0]                          neg;
    logic                                  zero;
    logic [vnorm_pkg::LENGTH_BITS-1:0]     len;
  } div_side_t;

  logic en;
  logic sk_valid;
  vnorm_pkg::res_beat_t sk_data;

  assign en        = !sk_valid;
  assign vec_stall = sk_valid;

  // Front: magnitudes, squares and a two-level sum.
  logic signed [L-1:0][N-1:0] comp;
  logic [L-1:0][N-1:0]        mag1, mag2, mag3, mag4;
  logic [L-1:0]               neg1, neg2, neg3, neg4;
  logic [L-1:0][2*N-1:0]      sq2;
  logic [1:0][SUM_W-1:0]      p3;
  logic [SUM_W-1:0]           sum4;
  logic                       v1, v2, v3, v4;

  always_comb begin
    comp[0] = N'(vec_data.comp_x);
    comp[1] = N'(vec_data.comp_y);
    comp[2] = N'(vec_data.comp_z);
    comp[3] = N'(vec_data.comp_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= vec_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        neg1[l] <= comp[l][N-1];
        mag1[l] <= comp[l][N-1] ? N'(~comp[l] + 1'b1) : comp[l];
        sq2[l]  <= (2*N)'(mag1[l]) * (2*N)'(mag1[l]);
      end
      mag2 <= mag1;
      neg2 <= neg1;
      p3[0] <= SUM_W'(sq2[0]) + SUM_W'(sq2[1]);
      p3[1] <= SUM_W'(sq2[2]) + SUM_W'(sq2[3]);
      mag3 <= mag2;
      neg3 <= neg2;
      sum4 <= p3[0] + p3[1];
      mag4 <= mag3;
      neg4 <= neg3;
    end
  end

  // Normalization: shift the sum left by pairs of bits until a top pair is nonzero.
  logic [RAD_W:0]     sum_ext;
  logic               nv   [NORM_ST+1];
  logic [RAD_W-1:0]   nt   [NORM_ST+1];
  logic [4:0]         nk   [NORM_ST+1];
  sq_side_t           nsd  [NORM_ST+1];

  assign sum_ext = (RAD_W+1)'(sum4);

  always_comb begin
    nv[0]       = v4;
    nt[0]       = sum_ext[RAD_W-1:0];
    nk[0]       = '0;
    nsd[0].mag  = mag4;
    nsd[0].neg  = neg4;
    nsd[0].zero = (sum4 == '0);
    nsd[0].full = sum_ext[RAD_W];
    nsd[0].k    = '0;
  end

  for (genvar g = 0; g < NORM_ST; g++) begin : g_norm
    localparam int P = 16 >> g;
    logic             hit;
    assign hit = (nt[g][RAD_W-1 -: 2*P] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        nv[g+1] <= 1'b0;
      end else if (en) begin
        nv[g+1] <= nv[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nt[g+1]  <= hit ? (nt[g] << (2*P)) : nt[g];
        nk[g+1]  <= hit ? (nk[g] | 5'(P)) : nk[g];
        nsd[g+1] <= nsd[g];
      end
    end
  end

  // A sum that overflowed the radicand is already at full scale and takes no shift.
  sq_side_t sq_in_side;
  always_comb begin
    sq_in_side   = nsd[NORM_ST];
    sq_in_side.k = nsd[NORM_ST].full ? 5'd0 : nk[NORM_ST];
  end

  logic              sq_valid;
  logic [RB-1:0]     sq_root;
  sq_side_t          sq_side;

  vnorm_sqrt #(
    .SIDE_W($bits(sq_side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (nv[NORM_ST]),
    .rad      (nt[NORM_ST]),
    .in_side  (sq_in_side),
    .out_valid(sq_valid),
    .root     (sq_root),
    .out_side (sq_side)
  );

  // Prep: scale components into numerators, form divisor and length.
  logic [RB:0]                                      rf;
  logic [L-1:0][RB-1:0]                             m_c;
  logic [L-1:0][vnorm_pkg::NUM_BITS-1:0]            num_c, num_p;
  logic [6:0]                                       dsh;
  logic [RB:0]                                      lw;
  logic [vnorm_pkg::LENGTH_BITS-1:0]                len_c;
  logic [vnorm_pkg::DEN_BITS-1:0]                   den_p;
  div_side_t                                        dside_p;
  logic                                             vp;

  always_comb begin
    // The all-minimum vector at 32 bits overflows 64 bits; its root is exactly 2^32.
    rf = sq_side.full ? ((RB+1)'(1) << RB) : {1'b0, sq_root};
    for (int l = 0; l < L; l++) begin
      m_c[l]   = RB'(sq_side.mag[l]) << sq_side.k;
      num_c[l] = vnorm_pkg::NUM_BITS'({m_c[l], 15'd0}) + vnorm_pkg::NUM_BITS'(rf);
    end
    dsh   = 7'(int'(sq_side.k) + LEN_OFS);
    lw    = rf >> dsh;
    len_c = (lw > (RB+1)'(vnorm_pkg::LENGTH_MAX)) ? vnorm_pkg::LENGTH_MAX
                                                   : lw[vnorm_pkg::LENGTH_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_p        <= num_c;
      den_p        <= {rf, 1'b0};
      dside_p.neg  <= sq_side.neg;
      dside_p.zero <= sq_side.zero;
      dside_p.len  <= len_c;
    end
  end

  logic                                         dv_valid;
  logic [L-1:0][vnorm_pkg::QUOT_BITS-1:0]       dv_quot;
  div_side_t                                    dv_side;

  vnorm_div #(
    .SIDE_W($bits(div_side_t))
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vp),
    .num      (num_p),
    .den      (den_p),
    .in_side  (dside_p),
    .out_valid(dv_valid),
    .quot     (dv_quot),
    .out_side (dv_side)
  );

  // Sign and zero-vector handling on the way out.
  logic [L-1:0][vnorm_pkg::UNIT_BITS-1:0] unit_c;
  vnorm_pkg::res_beat_t                   last_data;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (dv_side.zero) begin
        unit_c[l] = '0;
      end else if (dv_side.neg[l]) begin
        unit_c[l] = vnorm_pkg::UNIT_BITS'(0) - vnorm_pkg::UNIT_BITS'(dv_quot[l]);
      end else begin
        unit_c[l] = vnorm_pkg::UNIT_BITS'(dv_quot[l]);
      end
    end
    last_data.unit_x   = unit_c[0];
    last_data.unit_y   = unit_c[1];
    last_data.unit_z   = unit_c[2];
    last_data.unit_w   = unit_c[3];
    last_data.length   = dv_side.zero ? '0 : dv_side.len;
    last_data.was_zero = dv_side.zero;
  end

  logic res_take;
  assign res_take = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (sk_valid) begin
      if (res_take) begin
        res_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end
    end else if (!res_valid || res_take) begin
      res_valid <= dv_valid;
    end else if (dv_valid) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid) begin
      if (res_take) begin
        res_data <= sk_data;
      end
    end else if (!res_valid || res_take) begin
      res_data <= last_data;
    end else if (dv_valid) begin
      sk_data <= last_data;
    end
  end

  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> res_valid)
    else $error("skid register holds a beat while the output register is empty");

  a_skid_held : assert property (@(posedge clk) disable iff (rst)
    (sk_valid && res_stall) |=> sk_valid)
    else $error("skid beat dropped while the output was stalled");

  a_zero_result : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.was_zero) |->
      (res_data.length == '0 && res_data.unit_x == '0 && res_data.unit_y == '0 &&
       res_data.unit_z == '0 && res_data.unit_w == '0))
    else $error("zero vector result carries nonzero fields");

endmodule

`default_nettype wire

// ===== src/vnorm_sqrt.sv =====
// Pipelined integer square root, two root bits resolved per stage.
`default_nettype none

module vnorm_sqrt #(
  parameter int SIDE_W = 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic [vnorm_pkg::RAD_BITS-1:0]     rad,
  input  wire logic [SIDE_W-1:0]                  in_side,
  output logic                                    out_valid,
  output logic [vnorm_pkg::ROOT_BITS-1:0]         root,
  output logic [SIDE_W-1:0]                       out_side
);

  localparam int RB     = vnorm_pkg::ROOT_BITS;
  localparam int STAGES = RB / 2;
  localparam int REM_W  = RB + 3;

  logic                              vld    [STAGES+1];
  logic [vnorm_pkg::RAD_BITS-1:0]    rad_s  [STAGES+1];
  logic [REM_W-1:0]                  rem_s  [STAGES+1];
  logic [RB-1:0]                     root_s [STAGES+1];
  logic [SIDE_W-1:0]                 side_s [STAGES+1];

  assign vld[0]    = in_valid;
  assign rad_s[0]  = rad;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = in_side;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam int I1 = RB - 1 - 2 * g;
    localparam int I2 = I1 - 1;
    logic [REM_W-1:0] r1, r2, t1, t2;
    logic [RB-1:0]    q1, q2;

    // Each step brings down two radicand bits and tries the next root bit.
    always_comb begin
      r1 = {rem_s[g][REM_W-3:0], rad_s[g][2*I1+1 -: 2]};
      t1 = {1'b0, root_s[g], 2'b01};
      if (r1 >= t1) begin
        r1 = r1 - t1;
        q1 = {root_s[g][RB-2:0], 1'b1};
      end else begin
        q1 = {root_s[g][RB-2:0], 1'b0};
      end
      r2 = {r1[REM_W-3:0], rad_s[g][2*I2+1 -: 2]};
      t2 = {1'b0, q1, 2'b01};
      if (r2 >= t2) begin
        r2 = r2 - t2;
        q2 = {q1[RB-2:0], 1'b1};
      end else begin
        q2 = {q1[RB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[g+1]  <= rad_s[g];
        rem_s[g+1]  <= r2;
        root_s[g+1] <= q2;
        side_s[g+1] <= side_s[g];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign root      = root_s[STAGES];
  assign out_side  = side_s[STAGES];

endmodule

`default_nettype wire

// ===== src/vnorm_div.sv =====
// Four-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module vnorm_div #(
  parameter int SIDE_W = 1
) (
  input  wire logic                                               clk,
  input  wire logic                                               rst,
  input  wire logic                                               en,
  input  wire logic                                               in_valid,
  input  wire logic [vnorm_pkg::LANES-1:0][vnorm_pkg::NUM_BITS-1:0] num,
  input  wire logic [vnorm_pkg::DEN_BITS-1:0]                     den,
  input  wire logic [SIDE_W-1:0]                                  in_side,
  output logic                                                    out_valid,
  output logic [vnorm_pkg::LANES-1:0][vnorm_pkg::QUOT_BITS-1:0]   quot,
  output logic [SIDE_W-1:0]                                       out_side
);

  localparam int STAGES = vnorm_pkg::QUOT_BITS;
  localparam int NB     = vnorm_pkg::NUM_BITS;
  localparam int L      = vnorm_pkg::LANES;

  logic                                 vld   [STAGES+1];
  logic [L-1:0][NB-1:0]                 rem_s [STAGES+1];
  logic [L-1:0][STAGES-1:0]             q_s   [STAGES+1];
  logic [vnorm_pkg::DEN_BITS-1:0]       den_s [STAGES+1];
  logic [SIDE_W-1:0]                    side_s[STAGES+1];

  assign vld[0]    = in_valid;
  assign rem_s[0]  = num;
  assign q_s[0]    = '0;
  assign den_s[0]  = den;
  assign side_s[0] = in_side;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam int J = STAGES - 1 - g;
    logic [NB-1:0]            sub;
    logic [L-1:0][NB-1:0]     rem_n;
    logic [L-1:0][STAGES-1:0] q_n;

    always_comb begin
      sub   = NB'(den_s[g]) << J;
      rem_n = rem_s[g];
      q_n   = q_s[g];
      for (int l = 0; l < L; l++) begin
        if (rem_s[g][l] >= sub) begin
          rem_n[l]  = rem_s[g][l] - sub;
          q_n[l][J] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g+1]  <= rem_n;
        q_s[g+1]    <= q_n;
        den_s[g+1]  <= den_s[g];
        side_s[g+1] <= side_s[g];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign quot      = q_s[STAGES];
  assign out_side  = side_s[STAGES];

endmodule

`default_nettype wire

// ===== tb/sv/vec4_normalize_core_tb.sv =====
// Self-checking testbench for the four-component fixed-point vector normalizer.
`default_nettype none

module vec4_normalize_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 vec_valid = 1'b0;
  logic                 vec_stall;
  vnorm_pkg::vec_beat_t vec_data = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  vnorm_pkg::res_beat_t res_data;

  vnorm_pkg::res_beat_t unit_queue[$];
  int        fail_count = 0;
  int        vectors_sent = 0;
  int        results_checked = 0;
  int        zero_vectors = 0;
  int        stall_mode = 0;
  bit        burst_mode = 1'b1;

  vec4_normalize_core uut (
    .clk(clk), .rst(rst),
    .vec_valid(vec_valid), .vec_stall(vec_stall), .vec_data(vec_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] root_floor(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  // Normalizes one vector, with the sum of squares pre-scaled by 4^k for precision.
  function automatic vnorm_pkg::res_beat_t normalize_vec(vnorm_pkg::vec_beat_t v);
    vnorm_pkg::res_beat_t o;
    logic [15:0] comp[4];
    logic [16:0] mag[4];
    logic [63:0] s, t, r, num, q, len;
    int          k, d;
    comp[0] = v.comp_x; comp[1] = v.comp_y; comp[2] = v.comp_z; comp[3] = v.comp_w;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = comp[i][15] ? 17'h10000 - {1'b0, comp[i]} : {1'b0, comp[i]};
      s += 64'(mag[i]) * 64'(mag[i]);
    end
    o = '0;
    if (s == 0) begin
      o.unit_x = comp[0]; o.unit_y = comp[1]; o.unit_z = comp[2]; o.unit_w = comp[3];
      o.was_zero = 1'b1;
      return o;
    end
    k = 0;
    t = s;
    while (t < (64'd1 << 62)) begin
      t = t << 2;
      k++;
    end
    r = root_floor(t);
    for (int i = 0; i < 4; i++) begin
      num = 64'(mag[i]) << (15 + k);
      q = (num + r) / (2 * r);
      if (q > 32767) q = 32767;
      comp[i] = comp[i][15] ? 16'(-q) : 16'(q);
    end
    o.unit_x = comp[0]; o.unit_y = comp[1]; o.unit_z = comp[2]; o.unit_w = comp[3];
    d = k + vnorm_pkg::COMPONENT_BITS - 16;
    len = (d >= 0) ? (r >> d) : (r << (-d));
    o.length = (len > 64'(vnorm_pkg::LENGTH_MAX)) ? vnorm_pkg::LENGTH_MAX
                                                  : len[vnorm_pkg::LENGTH_BITS-1:0];
    return o;
  endfunction

  task automatic send_vec(vnorm_pkg::vec_beat_t v);
    @(negedge clk);
    vec_valid <= 1'b1;
    vec_data  <= v;
    @(posedge clk);
    while (vec_stall) @(posedge clk);
    unit_queue.push_back(normalize_vec(v));
    vectors_sent++;
    if (v == '0) zero_vectors++;
    // Keep valid high across a burst; drop it only when a gap follows.
    if (!burst_mode || $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      vec_valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  endtask

  task automatic end_burst();
    @(negedge clk);
    vec_valid <= 1'b0;
  endtask

  task automatic drain_results();
    end_burst();
    while (unit_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(signed'($urandom_range(0, 8)) - 4);
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver stall pattern: changes mode now and then; includes no-stall stretches.
  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= ($urandom_range(0, 1) == 0);
        default: res_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    vnorm_pkg::res_beat_t want;
    if (!rst && res_valid && !res_stall) begin
      if (unit_queue.size() == 0) begin
        $error("result beat with no vector outstanding: %h", res_data);
        fail_count++;
      end else begin
        want = unit_queue.pop_front();
        results_checked++;
        if (res_data.unit_x !== want.unit_x) begin
          $error("unit_x expected %h actual %h", want.unit_x, res_data.unit_x);
          fail_count++;
        end
        if (res_data.unit_y !== want.unit_y) begin
          $error("unit_y expected %h actual %h", want.unit_y, res_data.unit_y);
          fail_count++;
        end
        if (res_data.unit_z !== want.unit_z) begin
          $error("unit_z expected %h actual %h", want.unit_z, res_data.unit_z);
          fail_count++;
        end
        if (res_data.unit_w !== want.unit_w) begin
          $error("unit_w expected %h actual %h", want.unit_w, res_data.unit_w);
          fail_count++;
        end
        if (res_data.length !== want.length) begin
          $error("length expected %h actual %h", want.length, res_data.length);
          fail_count++;
        end
        if (res_data.was_zero !== want.was_zero) begin
          $error("was_zero expected %b actual %b", want.was_zero, res_data.was_zero);
          fail_count++;
        end
      end
    end
  end

  task automatic test_corner_vectors();
    logic [15:0] c[8];
    vnorm_pkg::vec_beat_t v;
    c = '{16'h0000, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h1000, 16'hf000, 16'h5555};
    burst_mode = 1'b0;
    send_vec('0);
    send_vec('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_vec('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    send_vec('{16'h0001, 16'h0000, 16'h0000, 16'h0000});
    send_vec('{16'h0000, 16'h0000, 16'h0000, 16'hffff});
    send_vec('{16'h1000, 16'h0000, 16'h0000, 16'h0000});
    send_vec('{16'h0000, 16'hf000, 16'h0000, 16'h0000});
    send_vec('{16'h0000, 16'h0000, 16'h8000, 16'h0000});
    send_vec('{16'h0003, 16'h0004, 16'h0000, 16'h0000});
    for (int i = 0; i < 12; i++) begin
      v = '{c[$urandom_range(0, 7)], c[$urandom_range(0, 7)],
            c[$urandom_range(0, 7)], c[$urandom_range(0, 7)]};
      send_vec(v);
    end
    // Hold off until every outstanding result has come back.
    drain_results();
  endtask

  task automatic test_random_stream();
    burst_mode = 1'b1;
    for (int i = 0; i < 1450; i++) begin
      if (i % 300 == 299) burst_mode = ~burst_mode;
      send_vec('{rand_comp(), rand_comp(), rand_comp(), rand_comp()});
    end
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corner_vectors();
    test_random_stream();
    $display("Checked %0d results from %0d vectors, %0d of them zero vectors.",
             results_checked, vectors_sent, zero_vectors);
    $display("Inputs covered full-scale, tiny and random components under random stalls.");
    if (fail_count == 0 && unit_queue.size() == 0) begin
      $display("vec4_normalize_core verification clean");
    end else begin
      $display("vec4_normalize_core verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("vec4_normalize_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== vec4_normalize_core.f =====
src/vnorm_pkg.sv
src/vnorm_sqrt.sv
src/vnorm_div.sv
src/vec4_normalize_core.sv
tb/sv/vec4_normalize_core_tb.sv
